// ===== rtl/core/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
// Used by the remainder unit and the top level; no dependencies.
`timescale 1ns / 1ps

package cbm_pkg;

   localparam int DivW = 11;
   localparam int CntW = $clog2(DivW + 1);
   localparam int AddrW = 4;

   localparam logic [7:0] AddrSelect = 8'h00;
   localparam logic [7:0] AddrData   = 8'h01;

   localparam logic [1:0] CsrPrgTotal   = 2'd0;
   localparam logic [1:0] CsrChrTotal   = 2'd1;
   localparam logic [1:0] CsrFourScreen = 2'd2;

   localparam logic [1:0] MirrorVertical   = 2'd0;
   localparam logic [1:0] MirrorHorizontal = 2'd1;
   localparam logic [1:0] MirrorUnchanged  = 2'd2;

   typedef struct packed {
      logic            start;
      logic [DivW-1:0] dividend;
      logic [7:0]      divisor;
   } mod_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] remainder;
   } mod_rsp_type;

endpackage

// ===== rtl/core/cbm_mod_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle.
// Depends on cbm_pkg for the request and response structs.
`timescale 1ns / 1ps

module cbm_mod_unit import cbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type mod_req,
   output mod_rsp_type mod_rsp
);

   logic [DivW-1:0] dividend_ff, dividend_in;
   logic [7:0]      divisor_ff, divisor_in;
   logic [7:0]      rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [8:0]      trial;

   always_comb begin
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      done_in     = 1'b0;
      trial       = {rem_ff, dividend_ff[DivW-1]};
      if (mod_req.start) begin
         dividend_in = mod_req.dividend;
         divisor_in  = mod_req.divisor;
         rem_in      = 8'd0;
         cnt_in      = CntW'(DivW);
      end else if (cnt_ff != '0) begin
         dividend_in = {dividend_ff[DivW-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = 8'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[7:0];
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

// ===== rtl/core/cartridge_bank_mapper_8259c.sv =====
// Bank mapper top level: register port, bank registers, sequencer and result register.
// Depends on cbm_pkg and cbm_mod_unit.
// Each accepted item runs three 11-step remainder operations on the shared unit
// plus six increment steps before its result is loaded into the result register.
// Not ready while busy: a new item is accepted only in idle, once the last is done.
// Reset (synchronous) clears the select, the bank registers and the configuration.
`timescale 1ns / 1ps

module cartridge_bank_mapper_8259c import cbm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [15:0]      req_bus_address,
   input  logic [7:0]       req_write_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_prg_switch_bank,
   output logic [7:0]       rsp_prg_fixed_bank,
   output logic [7:0]       rsp_chr_slot_0,
   output logic [7:0]       rsp_chr_slot_1,
   output logic [7:0]       rsp_chr_slot_2,
   output logic [7:0]       rsp_chr_slot_3,
   output logic [7:0]       rsp_chr_slot_4,
   output logic [7:0]       rsp_chr_slot_5,
   output logic [7:0]       rsp_chr_slot_6,
   output logic [7:0]       rsp_chr_slot_7,
   output logic [1:0]       rsp_mirror_mode,
   output logic             rsp_mapping_updated,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_PRG_START  = 4'd1;
   localparam logic [3:0] S_PRG_WAIT   = 4'd2;
   localparam logic [3:0] S_CHRA_START = 4'd3;
   localparam logic [3:0] S_CHRA_WAIT  = 4'd4;
   localparam logic [3:0] S_CHRA_STEP  = 4'd5;
   localparam logic [3:0] S_CHRB_START = 4'd6;
   localparam logic [3:0] S_CHRB_WAIT  = 4'd7;
   localparam logic [3:0] S_CHRB_STEP  = 4'd8;
   localparam logic [3:0] S_DONE       = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [7:0]  prg_total_ff, prg_total_in;
   logic [7:0]  chr_total_ff, chr_total_in;
   logic        four_ff, four_in;
   logic [2:0]  select_ff, select_in;
   logic [7:0]  bank_ff [8];
   logic [7:0]  bank_in [8];
   logic        updated_ff, updated_in;
   logic [7:0]  prg_sw_ff, prg_sw_in;
   logic [7:0]  chr_ff [8];
   logic [7:0]  chr_in [8];
   logic [7:0]  cur_ff, cur_in;
   logic [1:0]  slot_ff, slot_in;
   logic [8:0]  inc_sum;
   logic [7:0]  inc_wrap;
   logic [1:0]  slot_next;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_prg_sw_ff, out_prg_sw_in;
   logic [7:0]  out_prg_fix_ff, out_prg_fix_in;
   logic [7:0]  out_chr_ff [8];
   logic [7:0]  out_chr_in [8];
   logic [1:0]  out_mirror_ff, out_mirror_in;
   logic        out_updated_ff, out_updated_in;

   logic        cfg_write;
   logic        accept;
   logic        out_free;
   mod_req_type mod_req;
   mod_rsp_type mod_rsp;

   cbm_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      unique case (paddr[3:2])
         CsrPrgTotal:   prdata = {24'd0, prg_total_ff};
         CsrChrTotal:   prdata = {24'd0, chr_total_ff};
         CsrFourScreen: prdata = {31'd0, four_ff};
         default:       prdata = 32'd0;
      endcase
   end

   assign inc_sum   = {1'b0, cur_ff} + 9'd1;
   assign inc_wrap  = (inc_sum == {1'b0, chr_total_ff}) ? 8'd0 : inc_sum[7:0];
   assign slot_next = slot_ff + 2'd1;

   always_comb begin
      prg_total_in = prg_total_ff;
      chr_total_in = chr_total_ff;
      four_in      = four_ff;
      if (cfg_write) begin
         unique case (paddr[3:2])
            CsrPrgTotal:   prg_total_in = pwdata[7:0];
            CsrChrTotal:   chr_total_in = pwdata[7:0];
            CsrFourScreen: four_in      = pwdata[0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      select_in      = select_ff;
      bank_in        = bank_ff;
      updated_in     = updated_ff;
      prg_sw_in      = prg_sw_ff;
      chr_in         = chr_ff;
      cur_in         = cur_ff;
      slot_in        = slot_ff;
      out_valid_in   = out_valid_ff;
      out_prg_sw_in  = out_prg_sw_ff;
      out_prg_fix_in = out_prg_fix_ff;
      out_chr_in     = out_chr_ff;
      out_mirror_in  = out_mirror_ff;
      out_updated_in = out_updated_ff;
      mod_req.start    = 1'b0;
      mod_req.dividend = '0;
      mod_req.divisor  = prg_total_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               updated_in = 1'b0;
               if (req_bus_address[7:0] == AddrSelect) begin
                  select_in = req_write_data[2:0];
               end else if (req_bus_address[7:0] == AddrData) begin
                  bank_in[select_ff] = req_write_data;
                  updated_in = 1'b1;
               end
               state_in = S_PRG_START;
            end
         end
         S_PRG_START: begin
            mod_req.start    = 1'b1;
            mod_req.dividend = DivW'(bank_ff[5]);
            mod_req.divisor  = prg_total_ff;
            state_in = S_PRG_WAIT;
         end
         S_PRG_WAIT: begin
            if (mod_rsp.done) begin
               prg_sw_in = mod_rsp.remainder;
               state_in  = S_CHRA_START;
            end
         end
         S_CHRA_START: begin
            mod_req.start    = 1'b1;
            mod_req.dividend = {bank_ff[0], 3'b000};
            mod_req.divisor  = chr_total_ff;
            state_in = S_CHRA_WAIT;
         end
         S_CHRA_WAIT: begin
            if (mod_rsp.done) begin
               chr_in[0] = mod_rsp.remainder;
               cur_in    = mod_rsp.remainder;
               slot_in   = 2'd0;
               state_in  = S_CHRA_STEP;
            end
         end
         S_CHRA_STEP: begin
            chr_in[{1'b0, slot_next}] = inc_wrap;
            cur_in  = inc_wrap;
            slot_in = slot_next;
            if (slot_next == 2'd3) begin
               state_in = S_CHRB_START;
            end
         end
         S_CHRB_START: begin
            mod_req.start    = 1'b1;
            mod_req.dividend = {bank_ff[1], 3'b000};
            mod_req.divisor  = chr_total_ff;
            state_in = S_CHRB_WAIT;
         end
         S_CHRB_WAIT: begin
            if (mod_rsp.done) begin
               chr_in[4] = mod_rsp.remainder;
               cur_in    = mod_rsp.remainder;
               slot_in   = 2'd0;
               state_in  = S_CHRB_STEP;
            end
         end
         S_CHRB_STEP: begin
            chr_in[{1'b1, slot_next}] = inc_wrap;
            cur_in  = inc_wrap;
            slot_in = slot_next;
            if (slot_next == 2'd3) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (prg_total_ff != 8'd0) begin
                  out_prg_sw_in  = prg_sw_ff;
                  out_prg_fix_in = prg_total_ff - 8'd1;
               end else begin
                  out_prg_sw_in  = 8'd0;
                  out_prg_fix_in = 8'd0;
               end
               for (int i = 0; i < 8; i++) begin
                  out_chr_in[i] = (chr_total_ff != 8'd0) ? chr_ff[i] : 8'd0;
               end
               if (four_ff) begin
                  out_mirror_in = MirrorUnchanged;
               end else if (bank_ff[4][0]) begin
                  out_mirror_in = MirrorHorizontal;
               end else begin
                  out_mirror_in = MirrorVertical;
               end
               out_updated_in = updated_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prg_total_ff <= 8'd0;
         chr_total_ff <= 8'd0;
         four_ff      <= 1'b0;
         select_ff    <= 3'd0;
         for (int i = 0; i < 8; i++) begin
            bank_ff[i] <= 8'd0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prg_total_ff <= prg_total_in;
         chr_total_ff <= chr_total_in;
         four_ff      <= four_in;
         select_ff    <= select_in;
         bank_ff      <= bank_in;
         out_valid_ff <= out_valid_in;
      end
      updated_ff     <= updated_in;
      prg_sw_ff      <= prg_sw_in;
      chr_ff         <= chr_in;
      cur_ff         <= cur_in;
      slot_ff        <= slot_in;
      out_prg_sw_ff  <= out_prg_sw_in;
      out_prg_fix_ff <= out_prg_fix_in;
      out_chr_ff     <= out_chr_in;
      out_mirror_ff  <= out_mirror_in;
      out_updated_ff <= out_updated_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_prg_switch_bank = out_prg_sw_ff;
   assign rsp_prg_fixed_bank  = out_prg_fix_ff;
   assign rsp_chr_slot_0      = out_chr_ff[0];
   assign rsp_chr_slot_1      = out_chr_ff[1];
   assign rsp_chr_slot_2      = out_chr_ff[2];
   assign rsp_chr_slot_3      = out_chr_ff[3];
   assign rsp_chr_slot_4      = out_chr_ff[4];
   assign rsp_chr_slot_5      = out_chr_ff[5];
   assign rsp_chr_slot_6      = out_chr_ff[6];
   assign rsp_chr_slot_7      = out_chr_ff[7];
   assign rsp_mirror_mode     = out_mirror_ff;
   assign rsp_mapping_updated = out_updated_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_PRG_START))
      else $error("Accepted item did not start the program bank operation.");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (state_ff == S_PRG_WAIT || state_ff == S_CHRA_WAIT ||
                        state_ff == S_CHRB_WAIT))
      else $error("Remainder unit finished outside a wait state.");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_valid_ff && !rsp_ready) |=> (state_ff == S_DONE))
      else $error("Result register overwritten while the item was still waiting.");

   a_chr_range: assert property (@(posedge clock) disable iff (reset)
      ($rose(out_valid_ff) && chr_total_ff != 8'd0) |->
         (out_chr_ff[0] < chr_total_ff && out_chr_ff[3] < chr_total_ff &&
          out_chr_ff[4] < chr_total_ff && out_chr_ff[7] < chr_total_ff))
      else $error("Character bank out of range.");

   a_prg_range: assert property (@(posedge clock) disable iff (reset)
      ($rose(out_valid_ff) && prg_total_ff != 8'd0) |->
         (out_prg_sw_ff < prg_total_ff))
      else $error("Program bank out of range.");

endmodule
